### rtl/core/u8d_pkg.sv
// u8d_pkg: shared types, constants and lead-byte classification for the
// UTF-8 stream decoder. No dependencies.
`timescale 1ns / 1ps
package u8d_pkg;

  localparam int MAX_SEQ_BYTES = 6;
  localparam int CP_W          = 31;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW       = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            valid_res;
    logic [2:0]      seq_length;
    logic            last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic       single;
    logic       ok;
    logic [2:0] trails;
    logic [4:0] acc;
  } start_t;

  // Classify a byte seen with no sequence open.
  function automatic start_t start_decode(input logic [7:0] b);
    start_t     s;
    logic [2:0] zb;
    logic       found;
    logic [3:0] total;
    s     = '0;
    zb    = '0;
    found = 1'b0;
    for (int i = 6; i >= 0; i--) begin
      if (!found && !b[i]) begin
        zb    = 3'(i);
        found = 1'b1;
      end
    end
    total = 4'd7 - {1'b0, zb};
    if (!b[7]) begin
      s.single = 1'b1;
      s.ok     = 1'b1;
    end else if (!found || zb == 3'd6 || total > 4'(MAX_SEQ_BYTES)) begin
      s.single = 1'b1;
      s.ok     = 1'b0;
    end else begin
      s.single = 1'b0;
      s.trails = 3'(total - 4'd1);
      s.acc    = b[4:0] & ~(5'h1f << zb);
    end
    return s;
  endfunction

endpackage

### rtl/core/u8d_decode.sv
// u8d_decode: sequence state and single-pass byte decode, up to two results
// per byte. Depends on u8d_pkg.
`timescale 1ns / 1ps
module u8d_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        byte_in,
  output u8d_pkg::push_t    push
);

  logic [2:0]                 trails_r, trails_nxt;
  logic [u8d_pkg::CP_W-1:0]   acc_r, acc_nxt;
  logic [2:0]                 seen_r, seen_nxt;

  always_comb begin
    u8d_pkg::start_t          st;
    u8d_pkg::res_t            single_res;
    logic [u8d_pkg::CP_W-1:0] shifted;
    logic [2:0]               seen_inc;
    logic [2:0]               trails_dec;
    st         = u8d_pkg::start_decode(byte_in);
    shifted    = {acc_r[u8d_pkg::CP_W-7:0], byte_in[5:0]};
    seen_inc   = seen_r + 3'd1;
    trails_dec = trails_r - 3'd1;
    single_res.code_point = st.ok ? {(u8d_pkg::CP_W-8)'(0), byte_in} : '0;
    single_res.valid_res  = st.ok;
    single_res.seq_length = 3'd1;
    single_res.last       = 1'b1;

    push       = '0;
    trails_nxt = trails_r;
    acc_nxt    = acc_r;
    seen_nxt   = seen_r;

    if (trails_r == 3'd0) begin
      if (st.single) begin
        push.cnt = 2'd1;
        push.r0  = single_res;
      end else begin
        trails_nxt = st.trails;
        acc_nxt    = {(u8d_pkg::CP_W-5)'(0), st.acc};
        seen_nxt   = 3'd1;
      end
    end else if (byte_in[7:6] == 2'b10) begin
      trails_nxt = trails_dec;
      if (trails_dec == 3'd0) begin
        push.cnt           = 2'd1;
        push.r0.code_point = shifted;
        push.r0.valid_res  = 1'b1;
        push.r0.seq_length = seen_inc;
        push.r0.last       = 1'b1;
        acc_nxt            = '0;
        seen_nxt           = '0;
      end else begin
        acc_nxt  = shifted;
        seen_nxt = seen_inc;
      end
    end else begin
      // interrupted sequence: error for the open part, then restart
      push.r0.seq_length = seen_r;
      if (st.single) begin
        push.cnt   = 2'd2;
        push.r1    = single_res;
        trails_nxt = '0;
        acc_nxt    = '0;
        seen_nxt   = '0;
      end else begin
        push.cnt     = 2'd1;
        push.r0.last = 1'b1;
        trails_nxt   = st.trails;
        acc_nxt      = {(u8d_pkg::CP_W-5)'(0), st.acc};
        seen_nxt     = 3'd1;
      end
    end

    if (!step) begin
      push.cnt   = 2'd0;
      trails_nxt = trails_r;
      acc_nxt    = acc_r;
      seen_nxt   = seen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trails_r <= '0;
      acc_r    <= '0;
      seen_r   <= '0;
    end else begin
      trails_r <= trails_nxt;
      acc_r    <= acc_nxt;
      seen_r   <= seen_nxt;
    end
  end

endmodule

### rtl/core/u8d_out_fifo.sv
// u8d_out_fifo: small result queue taking up to two results per cycle and
// handing out one when out_ready is high. Depends on u8d_pkg.
`timescale 1ns / 1ps
module u8d_out_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  u8d_pkg::push_t              push,
  output logic [u8d_pkg::FIFO_CW-1:0] count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output u8d_pkg::res_t               head
);

  u8d_pkg::res_t               mem_r [u8d_pkg::FIFO_DEPTH];
  logic [u8d_pkg::FIFO_AW-1:0] wptr_r, wptr_nxt;
  logic [u8d_pkg::FIFO_AW-1:0] rptr_r, rptr_nxt;
  logic [u8d_pkg::FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic                        pop;
  logic [u8d_pkg::FIFO_AW-1:0] wptr_p1;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign head      = mem_r[rptr_r];
  assign count     = cnt_r;
  assign wptr_p1   = wptr_r + u8d_pkg::FIFO_AW'(1);

  always_comb begin
    wptr_nxt = wptr_r + u8d_pkg::FIFO_AW'(push.cnt);
    rptr_nxt = rptr_r + u8d_pkg::FIFO_AW'(pop);
    cnt_nxt  = cnt_r + u8d_pkg::FIFO_CW'(push.cnt) - u8d_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wptr_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

### rtl/core/utf8_stream_decoder_unit.sv
// utf8_stream_decoder_unit: top level, input register, decoder, result queue.
// Depends on u8d_pkg, u8d_decode, u8d_out_fifo.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    in_byte[7:0]
//   out      out_valid / out_ready  out_code_point[30:0], out_valid_res,
//                                   out_seq_length[2:0], out_last
//
// One byte per clock while the queue drains; each byte is registered first.
// The byte register feeds the decoder once the 4-entry result queue holds at
// most two results, so a byte giving two results always fits.
// in_ready depends only on internal state, never on out_ready.
// Synchronous active-low reset clears the open sequence and the queue.
`timescale 1ns / 1ps
module utf8_stream_decoder_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [u8d_pkg::CP_W-1:0]     out_code_point,
  output logic                         out_valid_res,
  output logic [2:0]                   out_seq_length,
  output logic                         out_last
);

  logic                        in_vld_r;
  logic [7:0]                  in_byte_r;
  logic                        advance;
  logic [u8d_pkg::FIFO_CW-1:0] count;
  u8d_pkg::push_t              push;
  u8d_pkg::res_t               head;

  assign advance  = in_vld_r &&
                    (count <= u8d_pkg::FIFO_CW'(u8d_pkg::FIFO_DEPTH - 2));
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_byte;
    end
  end

  u8d_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .byte_in (in_byte_r),
    .push    (push)
  );

  u8d_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .count     (count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_code_point = head.code_point;
  assign out_valid_res  = head.valid_res;
  assign out_seq_length = head.seq_length;
  assign out_last       = head.last;

endmodule
